[sv/lqm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lqm_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_MERGE  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_SELF  = 2'd3;

	typedef struct packed {
		logic value_we;
		logic link_we;
	} node_wr_t;

endpackage

`default_nettype wire

[sv/lqm_node_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module lqm_node_mem #(
	parameter int DEPTH = 256,
	parameter int VW    = 32,
	parameter int AW    = 8,
	parameter int LW    = 9
) (
	input  wire                   clk,
	input  lqm_pkg::node_wr_t     wr,
	input  wire  [AW-1:0]         val_addr,
	input  wire  [VW-1:0]         val_data,
	input  wire  [AW-1:0]         link_addr,
	input  wire  [LW-1:0]         link_data,
	input  wire  [AW-1:0]         rd_addr,
	output logic [VW-1:0]         rd_value,
	output logic [LW-1:0]         rd_link
);

	logic [VW-1:0] val_mem [DEPTH];
	logic [LW-1:0] link_mem [DEPTH];
	logic [VW-1:0] rd_value_q;
	logic [LW-1:0] rd_link_q;

	always_ff @(posedge clk) begin
		if (wr.value_we) begin
			val_mem[val_addr] <= val_data;
		end
		rd_value_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.link_we) begin
			link_mem[link_addr] <= link_data;
		end
		rd_link_q <= link_mem[rd_addr];
	end

	assign rd_value = rd_value_q;
	assign rd_link  = rd_link_q;

endmodule

`default_nettype wire

[sv/lqm_queue_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module lqm_queue_table #(
	parameter int NQ    = 4,
	parameter int QW    = 2,
	parameter int DEPTH = 256,
	parameter int LW    = 9,
	parameter int CW    = 9
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           rd_en,
	input  wire  [QW-1:0] rd_addr_a,
	input  wire  [QW-1:0] rd_addr_b,
	input  wire           wr_en,
	input  wire  [QW-1:0] wr_addr,
	input  wire  [LW-1:0] wr_head,
	input  wire  [LW-1:0] wr_tail,
	input  wire  [CW-1:0] wr_count,
	output logic [LW-1:0] a_head,
	output logic [LW-1:0] a_tail,
	output logic [CW-1:0] a_count,
	output logic [LW-1:0] b_head,
	output logic [LW-1:0] b_tail,
	output logic [CW-1:0] b_count
);

	localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

	logic [LW-1:0] head_mem [NQ];
	logic [LW-1:0] tail_mem [NQ];
	logic [CW-1:0] count_mem [NQ];
	logic [NQ-1:0] vld_q;

	logic [LW-1:0] a_head_q, a_tail_q, b_head_q, b_tail_q;
	logic [CW-1:0] a_count_q, b_count_q;

	// entries never written read as an empty queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			head_mem[wr_addr]  <= wr_head;
			tail_mem[wr_addr]  <= wr_tail;
			count_mem[wr_addr] <= wr_count;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			a_head_q  <= vld_q[rd_addr_a] ? head_mem[rd_addr_a]  : NULL_LINK;
			a_tail_q  <= vld_q[rd_addr_a] ? tail_mem[rd_addr_a]  : NULL_LINK;
			a_count_q <= vld_q[rd_addr_a] ? count_mem[rd_addr_a] : '0;
			b_head_q  <= vld_q[rd_addr_b] ? head_mem[rd_addr_b]  : NULL_LINK;
			b_tail_q  <= vld_q[rd_addr_b] ? tail_mem[rd_addr_b]  : NULL_LINK;
			b_count_q <= vld_q[rd_addr_b] ? count_mem[rd_addr_b] : '0;
		end
	end

	assign a_head  = a_head_q;
	assign a_tail  = a_tail_q;
	assign a_count = a_count_q;
	assign b_head  = b_head_q;
	assign b_tail  = b_tail_q;
	assign b_count = b_count_q;

endmodule

`default_nettype wire

[sv/linked_queue_manager_with_merge_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// NUM_QUEUES FIFO queues share a pool of POOL_DEPTH linked nodes. Each item is an
// insert, a remove, a merge (source queue linked onto the destination's tail in
// constant time) or a no-op and gives one result item: popped value (-1 if none),
// status and the target queue's new size. Items are processed one at a time from
// idle through the exec state, as the queue descriptor table and the node memories
// both have registered reads; a remove that pops a node adds the pop state (second
// node read of value and link), a merge of a non-empty source adds the clear state
// (second descriptor write to empty the source). A finished result waits in a skid
// register so the next item is taken while the output side stalls, unless one is
// already waiting. Nothing needs clearing after reset; the block is ready at once.
module linked_queue_manager_with_merge_core #(
	parameter int POOL_DEPTH  = 256,
	parameter int NUM_QUEUES  = 4,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  [1:0]                 op,
	input  wire  [$clog2(NUM_QUEUES)-1:0] queue_id,
	input  wire  [$clog2(NUM_QUEUES)-1:0] source_queue,
	input  wire  signed [VALUE_WIDTH-1:0] value,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [VALUE_WIDTH-1:0] removed_value,
	output logic [1:0]                 status,
	output logic [$clog2(POOL_DEPTH+1)-1:0] queue_size
);

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int LW = $clog2(POOL_DEPTH + 1);
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int VW = VALUE_WIDTH;
	localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_CLR  = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [1:0]    op_q;
	logic [QW-1:0] qi_q, si_q;
	logic [VW-1:0] val_q;
	logic [LW-1:0] free_head_q, free_head_d;
	logic [LW-1:0] nun_q, nun_d;

	logic          pend_valid_q;
	logic [VW-1:0] pend_val_q;
	logic [1:0]    pend_st_q;
	logic [CW-1:0] pend_sz_q;
	logic          out_valid_q;
	logic [VW-1:0] out_val_q;
	logic [1:0]    out_st_q;
	logic [CW-1:0] out_sz_q;

	logic          accept, out_free;
	logic [QW-1:0] q_in, s_in;

	logic [LW-1:0] rq_head, rq_tail, rs_head, rs_tail;
	logic [CW-1:0] rq_count, rs_count;
	logic          qt_we;
	logic [QW-1:0] qt_addr;
	logic [LW-1:0] qt_head, qt_tail;
	logic [CW-1:0] qt_count;

	lqm_pkg::node_wr_t nwr;
	logic [AW-1:0] val_addr, link_addr, rd_addr;
	logic [LW-1:0] link_data;
	logic [VW-1:0] rd_value;
	logic [LW-1:0] rd_link;

	logic          res_load;
	logic [VW-1:0] res_val;
	logic [1:0]    res_st;
	logic [CW-1:0] res_sz;

	logic          fh_ok, nun_ok, rdl_ok, rqh_ok, rqt_ok, rsh_ok, last;
	logic [LW-1:0] new_n;
	logic [CW-1:0] merged_cnt;

	// out-of-range queue ids wrap; the id is below twice NUM_QUEUES
	assign q_in = ({1'b0, queue_id} >= (QW+1)'(NUM_QUEUES)) ?
		queue_id - QW'(NUM_QUEUES) : queue_id;
	assign s_in = ({1'b0, source_queue} >= (QW+1)'(NUM_QUEUES)) ?
		source_queue - QW'(NUM_QUEUES) : source_queue;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || (pend_valid_q && !out_free);
	assign accept   = in_valid && !in_stall;

	lqm_queue_table #(
		.NQ(NUM_QUEUES), .QW(QW), .DEPTH(POOL_DEPTH), .LW(LW), .CW(CW)
	) u_qtab (
		.clk(clk), .arst_n(arst_n),
		.rd_en(accept), .rd_addr_a(q_in), .rd_addr_b(s_in),
		.wr_en(qt_we), .wr_addr(qt_addr),
		.wr_head(qt_head), .wr_tail(qt_tail), .wr_count(qt_count),
		.a_head(rq_head), .a_tail(rq_tail), .a_count(rq_count),
		.b_head(rs_head), .b_tail(rs_tail), .b_count(rs_count)
	);

	// idle: prefetch the free list successor; exec: fetch the head node for a pop
	assign rd_addr = (state_q == S_EXEC) ? rq_head[AW-1:0] : free_head_q[AW-1:0];

	lqm_node_mem #(
		.DEPTH(POOL_DEPTH), .VW(VW), .AW(AW), .LW(LW)
	) u_nodes (
		.clk(clk), .wr(nwr),
		.val_addr(val_addr), .val_data(val_q),
		.link_addr(link_addr), .link_data(link_data),
		.rd_addr(rd_addr), .rd_value(rd_value), .rd_link(rd_link)
	);

	assign fh_ok      = free_head_q < NULL_LINK;
	assign nun_ok     = nun_q < NULL_LINK;
	assign rdl_ok     = rd_link < NULL_LINK;
	assign rqh_ok     = rq_head < NULL_LINK;
	assign rqt_ok     = rq_tail < NULL_LINK;
	assign rsh_ok     = rs_head < NULL_LINK;
	assign last       = rq_head == rq_tail;
	assign new_n      = fh_ok ? free_head_q : nun_q;
	assign merged_cnt = rq_count + rs_count;
	assign val_addr   = new_n[AW-1:0];

	always_comb begin
		state_d     = state_q;
		free_head_d = free_head_q;
		nun_d       = nun_q;
		nwr         = '0;
		link_addr   = rq_tail[AW-1:0];
		link_data   = new_n;
		qt_we       = 1'b0;
		qt_addr     = qi_q;
		qt_head     = rq_head;
		qt_tail     = rq_tail;
		qt_count    = rq_count;
		res_load    = 1'b0;
		res_val     = '1;
		res_st      = lqm_pkg::ST_OK;
		res_sz      = rq_count;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (op_q)
					lqm_pkg::OP_INSERT: begin
						res_load = 1'b1;
						state_d  = S_IDLE;
						if (!fh_ok && !nun_ok) begin
							res_st = lqm_pkg::ST_FULL;
						end else begin
							nwr.value_we = 1'b1;
							nwr.link_we  = rqt_ok;
							qt_we        = 1'b1;
							qt_head      = rqt_ok ? rq_head : new_n;
							qt_tail      = new_n;
							qt_count     = rq_count + CW'(1);
							res_sz       = rq_count + CW'(1);
							if (fh_ok) begin
								free_head_d = rdl_ok ? rd_link : NULL_LINK;
							end else begin
								nun_d = nun_q + LW'(1);
							end
						end
					end
					lqm_pkg::OP_REMOVE: begin
						if (!rqh_ok) begin
							res_load = 1'b1;
							res_st   = lqm_pkg::ST_EMPTY;
							res_sz   = '0;
							state_d  = S_IDLE;
						end else begin
							state_d = S_POP;
						end
					end
					lqm_pkg::OP_MERGE: begin
						res_load = 1'b1;
						state_d  = S_IDLE;
						if (qi_q == si_q) begin
							res_st = lqm_pkg::ST_SELF;
						end else if (rsh_ok) begin
							nwr.link_we = rqh_ok;
							link_data   = rs_head;
							qt_we       = 1'b1;
							qt_head     = rqh_ok ? rq_head : rs_head;
							qt_tail     = rs_tail;
							qt_count    = merged_cnt;
							res_sz      = merged_cnt;
							state_d     = S_CLR;
						end
					end
					default: begin
						res_load = 1'b1;
						state_d  = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				// popped node goes to the front of the free list
				res_load    = 1'b1;
				res_val     = rd_value;
				nwr.link_we = 1'b1;
				link_addr   = rq_head[AW-1:0];
				link_data   = free_head_q;
				free_head_d = rq_head;
				qt_we       = 1'b1;
				qt_head     = (last || !rdl_ok) ? NULL_LINK : rd_link;
				qt_tail     = last ? NULL_LINK : rq_tail;
				qt_count    = last ? '0 : rq_count - CW'(1);
				res_sz      = last ? '0 : rq_count - CW'(1);
				state_d     = S_IDLE;
			end
			S_CLR: begin
				qt_we    = 1'b1;
				qt_addr  = si_q;
				qt_head  = NULL_LINK;
				qt_tail  = NULL_LINK;
				qt_count = '0;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_head_q  <= NULL_LINK;
			nun_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_head_q <= free_head_d;
			nun_q       <= nun_d;
			if (out_free) begin
				out_valid_q <= pend_valid_q;
			end
			if (res_load) begin
				pend_valid_q <= 1'b1;
			end else if (out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			qi_q  <= q_in;
			si_q  <= s_in;
			val_q <= value;
		end
		if (res_load) begin
			pend_val_q <= res_val;
			pend_st_q  <= res_st;
			pend_sz_q  <= res_sz;
		end
		if (out_free) begin
			out_val_q <= pend_val_q;
			out_st_q  <= pend_st_q;
			out_sz_q  <= pend_sz_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = out_val_q;
	assign status        = out_st_q;
	assign queue_size    = out_sz_q;

endmodule

`default_nettype wire
